@@ sv/protobuf_field_stream_parser_defines.svh @@
// Assertion macros for the protobuf field stream parser.
// No dependencies; included by files that carry concurrent assertions.
`ifndef PROTOBUF_FIELD_STREAM_PARSER_DEFINES_SVH
`define PROTOBUF_FIELD_STREAM_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
`define PFSP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PFSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PFSP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define PFSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ sv/pfsp_pkg.sv @@
// Shared types and constants for the protobuf field stream parser.
// No dependencies; used by pfsp_step, pfsp_out_reg and the top level.
package pfsp_pkg;

    localparam int MAX_MESSAGE_BYTES_DEF = 65536;

    localparam logic [2:0]  WT_VARINT = 3'd0;
    localparam logic [2:0]  WT_LEN    = 3'd2;
    localparam logic [31:0] NS_FIELD  = 32'd4;
    localparam logic [3:0]  VGRP_END  = 4'd10;

    typedef enum logic [2:0] {
        PH_PREFIX  = 3'd0,
        PH_TAG     = 3'd1,
        PH_VALUE   = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_SKIP    = 3'd5,
        PH_HALT    = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_VARINT    = 3'd1,
        EV_STR_BYTE  = 3'd2,
        EV_STR_EMPTY = 3'd3,
        EV_LEN_ERR   = 3'd4
    } t_event;

    typedef struct packed {
        t_phase      phase;
        logic [1:0]  pcount;
        logic [3:0]  vgrp;
        logic [2:0]  wtype;
        logic        sstart;
        logic        ns;
    } t_ctl;

    typedef struct packed {
        t_event      ev;
        logic [31:0] fnum;
        logic [63:0] val;
        logic [7:0]  sbyte;
        logic        first;
        logic        last;
        logic        mend;
        logic        mvalid;
    } t_result;

endpackage

@@ sv/pfsp_step.sv @@
// Per-byte decode logic: next parser state and the result item for one byte.
// Depends on pfsp_pkg.
module pfsp_step #(
    parameter int MAX_MESSAGE_BYTES = pfsp_pkg::MAX_MESSAGE_BYTES_DEF,
    parameter int CNT_W             = $clog2(MAX_MESSAGE_BYTES + 1)
) (
    input  logic [7:0]       i_byte,
    input  pfsp_pkg::t_ctl   i_ctl,
    input  logic [23:0]      i_pvalue,
    input  logic [CNT_W-1:0] i_body,
    input  logic [63:0]      i_acc,
    input  logic [31:0]      i_field,
    input  logic [CNT_W-1:0] i_srem,
    output pfsp_pkg::t_ctl   o_ctl,
    output logic [23:0]      o_pvalue,
    output logic [CNT_W-1:0] o_body,
    output logic [63:0]      o_acc,
    output logic [31:0]      o_field,
    output logic [CNT_W-1:0] o_srem,
    output pfsp_pkg::t_result o_res
);

    logic             in_body;
    logic             prefix_full;
    logic [31:0]      len32;
    logic             len_bad;
    logic [CNT_W-1:0] body_dec;
    logic             body_end;
    logic             vroom;
    logic [6:0]       vshift;
    logic [63:0]      acc_new;
    logic [3:0]       vgrp_new;
    logic             done;
    logic [31:0]      tag_field;
    logic [2:0]       tag_wt;
    logic             sz_bad;
    logic [CNT_W-1:0] srem_dec;
    logic             srem_end;
    logic             ns_set;
    logic             ns_clr;
    logic             ns_mid;

    assign in_body     = (i_ctl.phase != pfsp_pkg::PH_PREFIX) &&
                         (i_ctl.phase != pfsp_pkg::PH_HALT);
    assign prefix_full = (i_ctl.pcount == 2'd3);
    assign len32       = {i_pvalue, i_byte};
    assign len_bad     = (len32 == 32'd0) || (len32 > 32'(MAX_MESSAGE_BYTES));

    assign body_dec = i_body - CNT_W'(i_body != '0);
    assign body_end = (body_dec == '0);

    // varint bits above 63 are dropped
    assign vroom    = (i_ctl.vgrp < pfsp_pkg::VGRP_END);
    assign vshift   = {i_ctl.vgrp, 3'b000} - {3'b000, i_ctl.vgrp};
    assign acc_new  = vroom ? (i_acc | ({57'd0, i_byte[6:0]} << vshift)) : i_acc;
    assign vgrp_new = vroom ? (i_ctl.vgrp + 4'd1) : i_ctl.vgrp;
    assign done     = !i_byte[7] || body_end;

    assign tag_field = acc_new[34:3];
    assign tag_wt    = acc_new[2:0];
    assign sz_bad    = (acc_new == 64'd0) || (acc_new > 64'(body_dec));

    assign srem_dec = i_srem - CNT_W'(i_srem != '0);
    assign srem_end = (srem_dec == '0);

    assign ns_set = (i_ctl.phase == pfsp_pkg::PH_LEN) && done && !sz_bad &&
                    (i_field == pfsp_pkg::NS_FIELD);
    assign ns_clr = ((i_ctl.phase == pfsp_pkg::PH_LEN) && done && sz_bad &&
                     (i_field == pfsp_pkg::NS_FIELD)) ||
                    ((i_ctl.phase == pfsp_pkg::PH_TAG) && done && body_end &&
                     (tag_wt == pfsp_pkg::WT_LEN) && (tag_field == pfsp_pkg::NS_FIELD));
    assign ns_mid = ns_set ? 1'b1 : (ns_clr ? 1'b0 : i_ctl.ns);

    // next state
    always_comb begin
        o_ctl    = i_ctl;
        o_pvalue = i_pvalue;
        o_body   = i_body;
        o_acc    = i_acc;
        o_field  = i_field;
        o_srem   = i_srem;
        if (i_ctl.phase == pfsp_pkg::PH_PREFIX) begin
            o_ctl.pcount = i_ctl.pcount + 2'd1;
            if (prefix_full) begin
                o_pvalue = '0;
                if (len_bad) begin
                    o_ctl.phase = pfsp_pkg::PH_HALT;
                end else begin
                    o_body      = len32[CNT_W-1:0];
                    o_ctl.phase = pfsp_pkg::PH_TAG;
                    o_acc       = '0;
                    o_ctl.vgrp  = '0;
                    o_ctl.ns    = 1'b0;
                end
            end else begin
                o_pvalue = {i_pvalue[15:0], i_byte};
            end
        end else if (in_body) begin
            o_body   = body_dec;
            o_ctl.ns = ns_mid;
            unique case (i_ctl.phase)
                pfsp_pkg::PH_TAG: begin
                    o_acc      = acc_new;
                    o_ctl.vgrp = vgrp_new;
                    if (done) begin
                        o_field     = tag_field;
                        o_ctl.wtype = tag_wt;
                        o_acc       = '0;
                        o_ctl.vgrp  = '0;
                        if (!body_end) begin
                            if (tag_wt == pfsp_pkg::WT_VARINT) begin
                                o_ctl.phase = pfsp_pkg::PH_VALUE;
                            end else if (tag_wt == pfsp_pkg::WT_LEN) begin
                                o_ctl.phase = pfsp_pkg::PH_LEN;
                            end else begin
                                o_ctl.phase = pfsp_pkg::PH_SKIP;
                            end
                        end
                    end
                end
                pfsp_pkg::PH_VALUE: begin
                    o_acc      = acc_new;
                    o_ctl.vgrp = vgrp_new;
                    if (done) begin
                        o_acc       = '0;
                        o_ctl.vgrp  = '0;
                        o_ctl.phase = pfsp_pkg::PH_TAG;
                    end
                end
                pfsp_pkg::PH_LEN: begin
                    o_acc      = acc_new;
                    o_ctl.vgrp = vgrp_new;
                    if (done) begin
                        o_acc      = '0;
                        o_ctl.vgrp = '0;
                        if (sz_bad) begin
                            o_ctl.phase = pfsp_pkg::PH_TAG;
                        end else begin
                            o_srem       = acc_new[CNT_W-1:0];
                            o_ctl.sstart = 1'b0;
                            o_ctl.phase  = pfsp_pkg::PH_PAYLOAD;
                        end
                    end
                end
                pfsp_pkg::PH_PAYLOAD: begin
                    o_srem       = srem_dec;
                    o_ctl.sstart = 1'b1;
                    if (srem_end) begin
                        o_ctl.phase = pfsp_pkg::PH_TAG;
                        o_acc       = '0;
                        o_ctl.vgrp  = '0;
                    end
                end
                default: begin
                end
            endcase
            if (body_end) begin
                o_ctl.ns     = 1'b0;
                o_ctl.phase  = pfsp_pkg::PH_PREFIX;
                o_ctl.pcount = '0;
                o_pvalue     = '0;
                o_acc        = '0;
                o_ctl.vgrp   = '0;
                o_srem       = '0;
                o_ctl.sstart = 1'b0;
            end
        end
    end

    // result item
    always_comb begin
        o_res = '0;
        if (i_ctl.phase == pfsp_pkg::PH_PREFIX) begin
            if (prefix_full && len_bad) begin
                o_res.ev = pfsp_pkg::EV_LEN_ERR;
            end
        end else if (in_body) begin
            unique case (i_ctl.phase)
                pfsp_pkg::PH_TAG: begin
                    if (done && body_end) begin
                        if (tag_wt == pfsp_pkg::WT_VARINT) begin
                            o_res.ev   = pfsp_pkg::EV_VARINT;
                            o_res.fnum = tag_field;
                        end else if (tag_wt == pfsp_pkg::WT_LEN) begin
                            o_res.ev   = pfsp_pkg::EV_STR_EMPTY;
                            o_res.fnum = tag_field;
                        end
                    end
                end
                pfsp_pkg::PH_VALUE: begin
                    if (done) begin
                        o_res.ev   = pfsp_pkg::EV_VARINT;
                        o_res.fnum = i_field;
                        o_res.val  = acc_new;
                    end
                end
                pfsp_pkg::PH_LEN: begin
                    if (done && sz_bad) begin
                        o_res.ev   = pfsp_pkg::EV_STR_EMPTY;
                        o_res.fnum = i_field;
                    end
                end
                pfsp_pkg::PH_PAYLOAD: begin
                    o_res.ev    = pfsp_pkg::EV_STR_BYTE;
                    o_res.fnum  = i_field;
                    o_res.sbyte = i_byte;
                    o_res.first = !i_ctl.sstart;
                    o_res.last  = srem_end;
                end
                default: begin
                end
            endcase
            o_res.mend   = body_end;
            o_res.mvalid = body_end && ns_mid;
        end
    end

endmodule

@@ sv/pfsp_out_reg.sv @@
// Result register with valid/ready handshake toward the consumer.
// Depends on pfsp_pkg.
module pfsp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  pfsp_pkg::t_result i_res,
    input  logic              i_ready,
    output logic              o_valid,
    output pfsp_pkg::t_result o_res
);

    logic              r_valid;
    logic              n_valid;
    pfsp_pkg::t_result r_res;

    assign n_valid = i_load || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

@@ sv/protobuf_field_stream_parser.sv @@
// An accepted byte's result item enters the output register in the next cycle.
// Throughput: one byte per cycle; input ready drops only while a result waits unread.
// Per-byte state update is combinational logic in pfsp_step.
// Reset (synchronous, active low) returns to the length prefix phase and empties
// the output register; a bad frame length halts the parser until the next reset.
module protobuf_field_stream_parser #(
    parameter int MAX_MESSAGE_BYTES = pfsp_pkg::MAX_MESSAGE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_stream_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_event_res,
    output logic [31:0] o_field_number,
    output logic [63:0] o_varint_value,
    output logic [7:0]  o_string_byte,
    output logic        o_string_first,
    output logic        o_string_last,
    output logic        o_message_end,
    output logic        o_message_valid
);

`include "protobuf_field_stream_parser_defines.svh"

    localparam int CNT_W = $clog2(MAX_MESSAGE_BYTES + 1);

    pfsp_pkg::t_ctl    r_ctl;
    pfsp_pkg::t_ctl    n_ctl;
    logic [23:0]       r_pvalue;
    logic [23:0]       n_pvalue;
    logic [CNT_W-1:0]  r_body;
    logic [CNT_W-1:0]  n_body;
    logic [63:0]       r_acc;
    logic [63:0]       n_acc;
    logic [31:0]       r_field;
    logic [31:0]       n_field;
    logic [CNT_W-1:0]  r_srem;
    logic [CNT_W-1:0]  n_srem;
    pfsp_pkg::t_result step_res;
    pfsp_pkg::t_result out_res;
    logic              in_accept;

    assign o_in_ready = !o_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    pfsp_step #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES),
        .CNT_W             (CNT_W)
    ) u_step (
        .i_byte   (i_stream_byte),
        .i_ctl    (r_ctl),
        .i_pvalue (r_pvalue),
        .i_body   (r_body),
        .i_acc    (r_acc),
        .i_field  (r_field),
        .i_srem   (r_srem),
        .o_ctl    (n_ctl),
        .o_pvalue (n_pvalue),
        .o_body   (n_body),
        .o_acc    (n_acc),
        .o_field  (n_field),
        .o_srem   (n_srem),
        .o_res    (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl    <= '{phase: pfsp_pkg::PH_PREFIX, default: '0};
            r_pvalue <= '0;
            r_body   <= '0;
            r_acc    <= '0;
            r_field  <= '0;
            r_srem   <= '0;
        end else if (in_accept) begin
            r_ctl    <= n_ctl;
            r_pvalue <= n_pvalue;
            r_body   <= n_body;
            r_acc    <= n_acc;
            r_field  <= n_field;
            r_srem   <= n_srem;
        end
    end

    pfsp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_accept),
        .i_res   (step_res),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_res   (out_res)
    );

    assign o_event_res     = out_res.ev;
    assign o_field_number  = out_res.fnum;
    assign o_varint_value  = out_res.val;
    assign o_string_byte   = out_res.sbyte;
    assign o_string_first  = out_res.first;
    assign o_string_last   = out_res.last;
    assign o_message_end   = out_res.mend;
    assign o_message_valid = out_res.mvalid;

    `PFSP_ASSERT_NEXT(a_halt_silent, i_clk, i_rst_n, in_accept && (r_ctl.phase == pfsp_pkg::PH_HALT), o_out_valid && (o_event_res == pfsp_pkg::EV_NONE) && !o_message_end, "halted parser produced an event")
    `PFSP_ASSERT_NEXT(a_len_err_halts, i_clk, i_rst_n, in_accept && (step_res.ev == pfsp_pkg::EV_LEN_ERR), r_ctl.phase == pfsp_pkg::PH_HALT, "length error did not halt parser")
    `PFSP_ASSERT_NEXT(a_end_to_prefix, i_clk, i_rst_n, in_accept && step_res.mend, (r_ctl.phase == pfsp_pkg::PH_PREFIX) && (r_ctl.pcount == 2'd0) && !r_ctl.ns, "frame end did not return to prefix")

endmodule

@@ bench/protobuf_field_stream_parser_tb.sv @@
// Self-checking bench for protobuf_field_stream_parser: feeds framed protobuf bytes
// and compares every result item against a byte-level wire-format decoder kept here.
// Depends on pfsp_pkg and the parser RTL only.
`timescale 1ns / 1ps

module protobuf_field_stream_parser_tb;

    localparam logic [31:0] MAX_LEN     = 32'(pfsp_pkg::MAX_MESSAGE_BYTES_DEF);
    localparam logic [2:0]  WT_FIXED64  = 3'd1;
    localparam logic [2:0]  WT_SGROUP   = 3'd3;
    localparam logic [2:0]  WT_TOP      = 3'd7;
    localparam int          IDLE_LIMIT  = 2000;
    localparam int          RAND_BYTES  = 1250;

    typedef struct packed {
        logic [7:0] b;
        logic       drain;
    } t_feed;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  in_byte = '0;
    logic        out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [2:0]  o_event_res;
    logic [31:0] o_field_number;
    logic [63:0] o_varint_value;
    logic [7:0]  o_string_byte;
    logic        o_string_first;
    logic        o_string_last;
    logic        o_message_end;
    logic        o_message_valid;

    protobuf_field_stream_parser i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_stream_byte   (in_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_event_res     (o_event_res),
        .o_field_number  (o_field_number),
        .o_varint_value  (o_varint_value),
        .o_string_byte   (o_string_byte),
        .o_string_first  (o_string_first),
        .o_string_last   (o_string_last),
        .o_message_end   (o_message_end),
        .o_message_valid (o_message_valid)
    );

    initial forever #2 i_clk = ~i_clk;

    t_feed             stream_q[$];
    logic [7:0]        body_q[$];
    pfsp_pkg::t_result field_events_q[$];

    int err_cnt = 0;
    int in_cnt = 0;
    int frames_seen = 0;
    int ns_frames = 0;
    int varints_seen = 0;
    int sbytes_seen = 0;
    int empties_seen = 0;
    int idle_cyc = 0;
    logic [31:0] cyc = '0;

    // decoder state
    pfsp_pkg::t_phase ph = pfsp_pkg::PH_PREFIX;
    logic [1:0]  pcnt = '0;
    logic [31:0] pval = '0;
    logic [31:0] body_left = '0;
    logic [63:0] acc = '0;
    int unsigned shft = 0;
    logic [31:0] cur_fld = '0;
    logic [2:0]  cur_wt = '0;
    logic [31:0] str_left = '0;
    logic        str_started = 1'b0;
    logic        ns_set = 1'b0;

    function automatic void gather(input logic [7:0] b);
        if (shft < 64) begin
            acc |= {57'd0, b[6:0]} << shft;
            shft += 7;
        end
    endfunction

    function automatic pfsp_pkg::t_result decode_wire_byte(input logic [7:0] b);
        pfsp_pkg::t_result r;
        logic              fin;
        logic              done;
        logic [63:0]       sz;
        r = '0;
        if (ph == pfsp_pkg::PH_HALT) begin
            r = '0;
        end else if (ph == pfsp_pkg::PH_PREFIX) begin
            pval = {pval[23:0], b};
            pcnt = pcnt + 2'd1;
            if (pcnt == 2'd0) begin
                if (pval == 0 || pval > MAX_LEN) begin
                    ph = pfsp_pkg::PH_HALT;
                    r.ev = pfsp_pkg::EV_LEN_ERR;
                end else begin
                    body_left = pval;
                    ph = pfsp_pkg::PH_TAG;
                    acc = '0;
                    shft = 0;
                    ns_set = 1'b0;
                end
                pval = '0;
            end
        end else begin
            if (body_left > 0) body_left = body_left - 1;
            fin = (body_left == 0);
            done = !b[7] || fin;
            case (ph)
                pfsp_pkg::PH_TAG: begin
                    gather(b);
                    if (done) begin
                        cur_fld = acc[34:3];
                        cur_wt = acc[2:0];
                        acc = '0;
                        shft = 0;
                        if (fin) begin
                            if (cur_wt == pfsp_pkg::WT_VARINT) begin
                                r.ev = pfsp_pkg::EV_VARINT;
                                r.fnum = cur_fld;
                            end else if (cur_wt == pfsp_pkg::WT_LEN) begin
                                r.ev = pfsp_pkg::EV_STR_EMPTY;
                                r.fnum = cur_fld;
                                if (cur_fld == pfsp_pkg::NS_FIELD) ns_set = 1'b0;
                            end
                        end else if (cur_wt == pfsp_pkg::WT_VARINT) begin
                            ph = pfsp_pkg::PH_VALUE;
                        end else if (cur_wt == pfsp_pkg::WT_LEN) begin
                            ph = pfsp_pkg::PH_LEN;
                        end else begin
                            ph = pfsp_pkg::PH_SKIP;
                        end
                    end
                end
                pfsp_pkg::PH_VALUE: begin
                    gather(b);
                    if (done) begin
                        r.ev = pfsp_pkg::EV_VARINT;
                        r.fnum = cur_fld;
                        r.val = acc;
                        acc = '0;
                        shft = 0;
                        ph = pfsp_pkg::PH_TAG;
                    end
                end
                pfsp_pkg::PH_LEN: begin
                    gather(b);
                    if (done) begin
                        sz = acc;
                        acc = '0;
                        shft = 0;
                        if (sz == 0 || sz > {32'd0, body_left}) begin
                            r.ev = pfsp_pkg::EV_STR_EMPTY;
                            r.fnum = cur_fld;
                            if (cur_fld == pfsp_pkg::NS_FIELD) ns_set = 1'b0;
                            ph = pfsp_pkg::PH_TAG;
                        end else begin
                            str_left = sz[31:0];
                            str_started = 1'b0;
                            if (cur_fld == pfsp_pkg::NS_FIELD) ns_set = 1'b1;
                            ph = pfsp_pkg::PH_PAYLOAD;
                        end
                    end
                end
                pfsp_pkg::PH_PAYLOAD: begin
                    if (str_left > 0) str_left = str_left - 1;
                    r.ev = pfsp_pkg::EV_STR_BYTE;
                    r.fnum = cur_fld;
                    r.sbyte = b;
                    r.first = !str_started;
                    r.last = (str_left == 0);
                    str_started = 1'b1;
                    if (str_left == 0) begin
                        ph = pfsp_pkg::PH_TAG;
                        acc = '0;
                        shft = 0;
                    end
                end
                default: begin
                end
            endcase
            if (fin) begin
                r.mend = 1'b1;
                r.mvalid = ns_set;
                ns_set = 1'b0;
                ph = pfsp_pkg::PH_PREFIX;
                pcnt = '0;
                pval = '0;
                acc = '0;
                shft = 0;
                str_left = '0;
                str_started = 1'b0;
            end
        end
        return r;
    endfunction

    // mostly short gaps, a few long ones, none while cyc[9:8] == 3
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (cyc[9:8] == 2'b11 || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic put_body(input logic [7:0] b);
        body_q.insert(body_q.size(), b);
    endtask

    task automatic put_stream(input logic [7:0] b, input logic drain);
        t_feed f;
        f.b = b;
        f.drain = drain;
        stream_q.insert(stream_q.size(), f);
    endtask

    task automatic push_prefix(input logic [31:0] n, input logic drain);
        put_stream(n[31:24], drain);
        put_stream(n[23:16], 1'b0);
        put_stream(n[15:8], 1'b0);
        put_stream(n[7:0], 1'b0);
    endtask

    task automatic push_frame(input logic drain);
        push_prefix(32'(body_q.size()), drain);
        foreach (body_q[i]) put_stream(body_q[i], 1'b0);
        body_q.delete();
    endtask

    task automatic add_frame(input int n, input logic [255:0] v);
        for (int i = 0; i < n; i++) put_body(v[8*(n-1-i) +: 8]);
        push_frame(1'b0);
    endtask

    // occasionally over-long, with redundant zero groups
    task automatic put_varint(input logic [63:0] v);
        int pad;
        pad = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 6) : 0;
        while (v > 127 || pad > 0) begin
            put_body({1'b1, v[6:0]});
            if (v <= 127) pad--;
            v = v >> 7;
        end
        put_body({1'b0, v[6:0]});
    endtask

    task automatic add_field();
        int unsigned r;
        int unsigned n;
        logic [63:0] fld;
        logic [2:0]  wt;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            repeat ($urandom_range(1, 3)) put_body(8'($urandom));
            return;
        end
        case ($urandom_range(0, 9))
            0, 1, 2: fld = 64'(pfsp_pkg::NS_FIELD);
            3, 4, 5: fld = 64'($urandom_range(0, 15));
            6, 7:    fld = 64'($urandom_range(16, 4095));
            8:       fld = 64'($urandom);
            default: fld = {$urandom, $urandom} >> 3;
        endcase
        r = $urandom_range(0, 99);
        if (r < 45) wt = pfsp_pkg::WT_VARINT;
        else if (r < 94) wt = pfsp_pkg::WT_LEN;
        else if (r < 96) wt = WT_FIXED64;
        else wt = 3'($urandom_range(WT_SGROUP, WT_TOP));
        put_varint({fld[60:0], wt});
        if (wt == pfsp_pkg::WT_VARINT) begin
            put_varint({$urandom, $urandom} >> $urandom_range(0, 63));
        end else if (wt == pfsp_pkg::WT_LEN) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                put_varint(64'd0);
            end else if (r < 93) begin
                n = (r < 85) ? $urandom_range(1, 12) : $urandom_range(13, 60);
                put_varint(64'(n));
                repeat (n) put_body(8'($urandom));
            end else begin
                put_varint(({$urandom, $urandom} >> $urandom_range(0, 50)) | 64'd64);
            end
        end
    endtask

    task automatic gen_frame(input int n);
        while (body_q.size() < n) add_field();
        while (body_q.size() > n) void'(body_q.pop_back());
        push_frame($urandom_range(0, 99) < 8);
    endtask

    // driver
    always @(posedge i_clk) begin : drv
        t_feed nxt;
        int    gap;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap = 0;
        end else begin
            if (in_valid && o_in_ready) begin
                field_events_q.push_back(decode_wire_byte(in_byte));
                in_cnt++;
            end
            if (!in_valid || o_in_ready) begin
                if (gap > 0) begin
                    gap--;
                    in_valid <= 1'b0;
                end else if (stream_q.size() == 0 ||
                             (stream_q[0].drain && field_events_q.size() > 0)) begin
                    in_valid <= 1'b0;
                end else begin
                    nxt = stream_q.pop_front();
                    in_byte <= nxt.b;
                    in_valid <= 1'b1;
                    gap = pick_gap();
                end
            end
        end
    end

    function automatic void cmp_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_cnt++;
        end
    endfunction

    // monitor
    always @(posedge i_clk) begin : mon
        pfsp_pkg::t_result want;
        int                stall;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            stall = 0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (field_events_q.size() == 0) begin
                    $error("result item with nothing expected: event_res %0d", o_event_res);
                    err_cnt++;
                end else begin
                    want = field_events_q.pop_front();
                    cmp_field("event_res", 64'(want.ev), 64'(o_event_res));
                    cmp_field("field_number", 64'(want.fnum), 64'(o_field_number));
                    cmp_field("varint_value", want.val, o_varint_value);
                    cmp_field("string_byte", 64'(want.sbyte), 64'(o_string_byte));
                    cmp_field("string_first", 64'(want.first), 64'(o_string_first));
                    cmp_field("string_last", 64'(want.last), 64'(o_string_last));
                    cmp_field("message_end", 64'(want.mend), 64'(o_message_end));
                    cmp_field("message_valid", 64'(want.mvalid), 64'(o_message_valid));
                    if (want.ev == pfsp_pkg::EV_VARINT) varints_seen++;
                    if (want.ev == pfsp_pkg::EV_STR_BYTE) sbytes_seen++;
                    if (want.ev == pfsp_pkg::EV_STR_EMPTY) empties_seen++;
                    if (want.mend) frames_seen++;
                    if (want.mvalid) ns_frames++;
                end
            end
            if (stall > 0) begin
                stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready))
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= IDLE_LIMIT) begin
            $display("[protobuf_field_stream_parser] ERROR");
            $finish;
        end
    end

    initial begin : stim
        int          rand_cnt;
        int          n;
        int unsigned r;
        logic [31:0] bad_len;
        rand_cnt = 0;

        // varint 150, field 4 string, oversize length, field 4 closing the frame
        add_frame(12, 256'(96'h08_96_01_22_02_FF_00_12_7F_22_01_80));
        // varint past 64 bits, then a skipped wire type
        add_frame(16, 256'(128'h00_FFFFFFFFFFFFFFFFFFFFFF_01_0D_55_AA));
        // length-delimited tag ending the frame
        add_frame(1, 256'(8'hA2));
        // field 4 set then emptied, frame ends inside a varint value
        add_frame(7, 256'(56'h22_01_41_22_00_10_FF));
        // frame ends inside a length varint
        add_frame(2, 256'(16'h0A_85));

        while (rand_cnt < RAND_BYTES) begin
            r = $urandom_range(0, 99);
            if (r < 80) n = $urandom_range(1, 30);
            else if (r < 97) n = $urandom_range(31, 200);
            else n = $urandom_range(201, 700);
            gen_frame(n);
            rand_cnt += n + 4;
        end

        // bad length halts the parser for good
        case ($urandom_range(0, 2))
            0:       bad_len = '0;
            1:       bad_len = MAX_LEN + 1;
            default: bad_len = MAX_LEN + 1 + $urandom_range(0, 32'hFFFE_FFFE);
        endcase
        push_prefix(bad_len, 1'b1);
        repeat (12) put_stream(8'($urandom), 1'b0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (stream_q.size() > 0 || in_valid || field_events_q.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Fed %0d bytes; %0d frames closed, %0d with namespace field 4 set.",
                 in_cnt, frames_seen, ns_frames);
        $display("Checked %0d varint fields, %0d string bytes, %0d empty fields;",
                 varints_seen, sbytes_seen, empties_seen);
        $display("halted on length %0h.", bad_len);
        if (err_cnt == 0)
            $display("[protobuf_field_stream_parser] OK");
        else
            $display("[protobuf_field_stream_parser] ERROR");
        $finish;
    end

endmodule
